// ----- rtl/core/edfr_pkg.sv -----
`timescale 1ns / 1ps
package edfr_pkg;

   localparam logic [63:0] SIN_A = 64'd1686629713;
   localparam logic [63:0] SIN_B = 64'd688904866;
   localparam logic [63:0] SIN_C = 64'd76016977;

   // Register stages from the request edge to the response register.
   localparam int PIPE_DEPTH = 13;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic signed [31:0] world_pos_x;
      logic signed [31:0] world_pos_y;
      logic signed [31:0] world_pos_z;
      logic signed [31:0] world_vel_x;
      logic signed [31:0] world_vel_y;
      logic signed [31:0] world_vel_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] body_pos_x;
      logic signed [31:0] body_pos_y;
      logic signed [31:0] body_pos_z;
      logic signed [31:0] body_vel_x;
      logic signed [31:0] body_vel_y;
      logic signed [31:0] body_vel_z;
   } rsp_type;

   // Phase folding: 14-bit first-quadrant phase scaled to Q30 (at most 2^30).
   function automatic logic [30:0] sin_fold(input logic [15:0] a);
      logic [14:0] z;
      begin
         z = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
         sin_fold = {z, 16'd0};
      end
   endfunction

   // Round a Q60 product to Q30 (floor with half added).
   function automatic logic signed [32:0] rnd30(input logic signed [65:0] p);
      logic signed [65:0] t;
      begin
         t = p + 66'sd536870912;
         rnd30 = t[62:30];
      end
   endfunction

endpackage

// ----- rtl/core/edfr_if.sv -----
`timescale 1ns / 1ps
interface edfr_req_if import edfr_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface edfr_rsp_if import edfr_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/euler_dcm_frame_rotation.sv -----
`timescale 1ns / 1ps
// Euler 3-2-1 direction cosine rotation of a pose request into the body frame.
// The req channel carries roll, pitch and yaw binary angles plus a world
// position and velocity; the rsp channel returns body position and velocity in
// saturated Q16.16. Both channels are valid/ready; a request moves on an edge
// where both are high.
// The pipeline has thirteen register stages, from the fold stage to the rsp
// output register. One request is taken every cycle unless the rsp receiver
// stalls, since every stage is a register of its own and none is reused;
// the multipliers in the sine polynomial, the matrix products and the vector
// products only set how many stages there are.
// All stages advance together on one enable: when the rsp receiver stalls and
// the last stage holds a result, the whole pipeline holds, and req_ready drops
// only then, so nothing is lost or repeated. A bubble moves on freely.
// Reset is synchronous and active high; it clears every valid bit. The block
// keeps no state between requests.
module euler_dcm_frame_rotation
   import edfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   edfr_req_if.sink    req,
   edfr_rsp_if.source  rsp
);

   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  adv;

   // Holding stalls everything only when the output holds an unsent result.
   assign adv = !vld_ff[PIPE_DEPTH-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req.valid};
      end
   end

   // Six angles: sr, cr, sp, cp, sy, cy.  Sine stages for each.
   logic [15:0]  ang_in [6];
   assign ang_in[0] = req.data.roll_angle;
   assign ang_in[1] = req.data.roll_angle + 16'h4000;
   assign ang_in[2] = req.data.pitch_angle;
   assign ang_in[3] = req.data.pitch_angle + 16'h4000;
   assign ang_in[4] = req.data.yaw_angle;
   assign ang_in[5] = req.data.yaw_angle + 16'h4000;

   logic [30:0]  x1_ff  [6];
   logic         ng1_ff [6];
   logic [30:0]  x2_ff  [6];
   logic         ng2_ff [6];
   logic [30:0]  xx_ff  [6];
   logic [30:0]  x3_ff  [6];
   logic         ng3_ff [6];
   logic [31:0]  t_ff   [6];
   logic [30:0]  xx4_ff [6];
   logic [30:0]  x4_ff  [6];
   logic         ng4_ff [6];
   logic [31:0]  v_ff   [6];
   logic signed [31:0] s_ff [6];

   // Vector pass-along; negated navigation vector (33 bits holds +2^31).
   req_type d_ff [6];

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0] <= req.data;
         for (int k = 1; k < 6; k++) d_ff[k] <= d_ff[k-1];
         for (int i = 0; i < 6; i++) begin
            logic [63:0] pm;
            logic [63:0] pt;
            // stage 1: fold
            x1_ff[i]  <= sin_fold(ang_in[i]);
            ng1_ff[i] <= ang_in[i][15];
            // stage 2: X^2
            pm = 64'(x1_ff[i]) * 64'(x1_ff[i]);
            xx_ff[i]  <= pm[60:30];
            x2_ff[i]  <= x1_ff[i];
            ng2_ff[i] <= ng1_ff[i];
            // stage 3: C*X2
            pm = SIN_C * 64'(xx_ff[i]);
            t_ff[i]   <= pm[61:30];
            xx4_ff[i] <= xx_ff[i];
            x3_ff[i]  <= x2_ff[i];
            ng3_ff[i] <= ng2_ff[i];
            // stage 4: (B-t)*X2
            pt = SIN_B - 64'(t_ff[i]);
            pm = pt * 64'(xx4_ff[i]);
            v_ff[i]   <= pm[61:30];
            x4_ff[i]  <= x3_ff[i];
            ng4_ff[i] <= ng3_ff[i];
            // stage 5: w*X
            pt = SIN_A - 64'(v_ff[i]);
            pm = pt * 64'(x4_ff[i]);
            s_ff[i]   <= ng4_ff[i] ? -$signed(pm[61:30]) : $signed(pm[61:30]);
         end
      end
   end

   // stage 6: pair products
   logic signed [32:0] srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff;
   logic signed [32:0] srcp_ff, srsy_ff, srcy_ff, crcp_ff, sy6_ff, cy6_ff;
   logic signed [32:0] nsp6_ff;
   // stage 7: triple products
   logic signed [32:0] m00_7_ff, m01_7_ff, m02_7_ff, m12_7_ff, m22_7_ff;
   logic signed [32:0] crsy7_ff, crcy7_ff, srsy7_ff, srcy7_ff;
   logic signed [32:0] t10_ff, t11_ff, t20_ff, t21_ff;
   // stage 8: matrix
   logic signed [33:0] m_ff [9];

   always_ff @(posedge clock) begin
      if (adv) begin
         srsp_ff <= rnd30(66'(s_ff[0]) * 66'(s_ff[2]));
         crsp_ff <= rnd30(66'(s_ff[1]) * 66'(s_ff[2]));
         cpcy_ff <= rnd30(66'(s_ff[3]) * 66'(s_ff[5]));
         cpsy_ff <= rnd30(66'(s_ff[3]) * 66'(s_ff[4]));
         crsy_ff <= rnd30(66'(s_ff[1]) * 66'(s_ff[4]));
         crcy_ff <= rnd30(66'(s_ff[1]) * 66'(s_ff[5]));
         srcp_ff <= rnd30(66'(s_ff[0]) * 66'(s_ff[3]));
         srsy_ff <= rnd30(66'(s_ff[0]) * 66'(s_ff[4]));
         srcy_ff <= rnd30(66'(s_ff[0]) * 66'(s_ff[5]));
         crcp_ff <= rnd30(66'(s_ff[1]) * 66'(s_ff[3]));
         sy6_ff  <= 33'(s_ff[4]);
         cy6_ff  <= 33'(s_ff[5]);
         nsp6_ff <= -33'(s_ff[2]);

         t10_ff   <= rnd30(66'(srsp_ff) * 66'(cy6_ff));
         t11_ff   <= rnd30(66'(srsp_ff) * 66'(sy6_ff));
         t20_ff   <= rnd30(66'(crsp_ff) * 66'(cy6_ff));
         t21_ff   <= rnd30(66'(crsp_ff) * 66'(sy6_ff));
         m00_7_ff <= cpcy_ff;
         m01_7_ff <= cpsy_ff;
         m02_7_ff <= nsp6_ff;
         m12_7_ff <= srcp_ff;
         m22_7_ff <= crcp_ff;
         crsy7_ff <= crsy_ff;
         crcy7_ff <= crcy_ff;
         srsy7_ff <= srsy_ff;
         srcy7_ff <= srcy_ff;

         m_ff[0] <= 34'(m00_7_ff);
         m_ff[1] <= 34'(m01_7_ff);
         m_ff[2] <= 34'(m02_7_ff);
         m_ff[3] <= 34'(t10_ff) - 34'(crsy7_ff);
         m_ff[4] <= 34'(t11_ff) + 34'(crcy7_ff);
         m_ff[5] <= 34'(m12_7_ff);
         m_ff[6] <= 34'(t20_ff) + 34'(srsy7_ff);
         m_ff[7] <= 34'(t21_ff) - 34'(srcy7_ff);
         m_ff[8] <= 34'(m22_7_ff);
      end
   end

   // Navigation vectors, aligned with the matrix (stage 8).
   logic signed [32:0] n_ff [2][6];
   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff[0][0] <= -33'(d_ff[5].world_pos_y);
         n_ff[0][1] <= -33'(d_ff[5].world_pos_x);
         n_ff[0][2] <= -33'(d_ff[5].world_pos_z);
         n_ff[0][3] <= -33'(d_ff[5].world_vel_y);
         n_ff[0][4] <= -33'(d_ff[5].world_vel_x);
         n_ff[0][5] <= -33'(d_ff[5].world_vel_z);
         n_ff[1] <= n_ff[0];
      end
   end

   function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
      if (v > 54'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -54'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

   // Stage 9-10: each of 18 products split in a 16-bit low and a 17-bit high
   // half of the vector; stage 9 both partials, stage 10 combine and floor by 16.
   logic signed [50:0] plo_ff [6][3];
   logic signed [50:0] phi_ff [6][3];
   logic signed [51:0] q_ff   [6][3];
   logic signed [53:0] acc_ff [6];
   logic signed [53:0] r_ff   [6];
   rsp_type            out_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int o = 0; o < 6; o++) begin
            for (int c = 0; c < 3; c++) begin
               logic signed [32:0] nv;
               logic signed [67:0] full;
               nv = n_ff[1][(o / 3) * 3 + c];
               plo_ff[o][c] <= 51'(m_ff[(o % 3) * 3 + c])
                               * 51'($signed({1'b0, nv[15:0]}));
               phi_ff[o][c] <= 51'(m_ff[(o % 3) * 3 + c])
                               * 51'($signed(nv[32:16]));
               full = (68'(phi_ff[o][c]) <<< 16) + 68'(plo_ff[o][c]);
               q_ff[o][c] <= 52'(full >>> 16);
            end
            acc_ff[o] <= 54'(q_ff[o][0]) + 54'(q_ff[o][1]) + 54'(q_ff[o][2])
                         + 54'sd8192;
            r_ff[o] <= acc_ff[o] >>> 14;
         end
         out_ff.body_pos_x <= sat32(r_ff[0]);
         out_ff.body_pos_y <= sat32(r_ff[1]);
         out_ff.body_pos_z <= sat32(r_ff[2]);
         out_ff.body_vel_x <= sat32(r_ff[3]);
         out_ff.body_vel_y <= sat32(r_ff[4]);
         out_ff.body_vel_z <= sat32(r_ff[5]);
      end
   end

   assign rsp.valid = vld_ff[PIPE_DEPTH-1];
   assign rsp.data  = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("stalled response changed");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("pipeline stalled with empty output");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && (&vld_ff == 1'b0) |-> ##0 adv)
      else $error("request taken without advance");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import edfr_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   edfr_req_if req_ch ();
   edfr_rsp_if rsp_ch ();

   euler_dcm_frame_rotation DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   // Requests waiting to be driven, and body-frame results still owed by the block.
   req_type pending_reqs[$];
   rsp_type owed_body[$];

   int unsigned mismatches = 0;
   int unsigned n_sent = 0;
   int unsigned n_checked = 0;
   int unsigned cycle_count = 0;
   bit stim_done = 1'b0;
   bit calm_phase = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;

   localparam int unsigned CYCLE_LIMIT = 200000;

   // Floor division by a power of two; >>> on a signed value floors already.
   function automatic logic signed [127:0] floor_shift(input logic signed [127:0] v,
                                                       input int n);
      return v >>> n;
   endfunction

   // Q30 sine from the piecewise polynomial, using the angle as a 16-bit phase.
   function automatic logic signed [63:0] poly_sine(input logic [15:0] ang);
      logic [1:0] quad;
      logic [13:0] ph;
      logic [63:0] zv, xq, x2, t, v, w, s;
      quad = ang[15:14];
      ph = ang[13:0];
      zv = quad[0] ? (64'd16384 - ph) : {50'd0, ph};
      xq = zv << 16;
      x2 = (xq * xq) >> 30;
      t = (64'd76016977 * x2) >> 30;
      v = ((64'd688904866 - t) * x2) >> 30;
      w = 64'd1686629713 - v;
      s = (w * xq) >> 30;
      return quad[1] ? -$signed(s) : $signed(s);
   endfunction

   // Rounded Q30 product of two Q30 values.
   function automatic logic signed [63:0] q30_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b) + 128'sd536870912;
      return 64'(floor_shift(p, 30));
   endfunction

   // One matrix row times the navigation vector, rounded to Q16.16 and saturated.
   function automatic logic signed [31:0] row_dot(input logic signed [63:0] r0,
                                                  input logic signed [63:0] r1,
                                                  input logic signed [63:0] r2,
                                                  input logic signed [63:0] n0,
                                                  input logic signed [63:0] n1,
                                                  input logic signed [63:0] n2);
      logic signed [127:0] acc;
      acc = floor_shift(128'(r0) * 128'(n0), 16) + floor_shift(128'(r1) * 128'(n1), 16)
          + floor_shift(128'(r2) * 128'(n2), 16);
      acc = floor_shift(acc + 128'sd8192, 14);
      if (acc > 128'sd2147483647) return 32'sh7fffffff;
      if (acc < -128'sd2147483648) return 32'sh80000000;
      return acc[31:0];
   endfunction

   // Predicts the body-frame pose for one request.
   function automatic rsp_type rotate_to_body(input req_type r);
      logic signed [63:0] sr, cr, sp, cp, sy, cy, srsp, crsp;
      logic signed [63:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
      logic signed [63:0] p0, p1, p2, v0, v1, v2;
      rsp_type o;
      sr = poly_sine(r.roll_angle);
      cr = poly_sine(r.roll_angle + 16'h4000);
      sp = poly_sine(r.pitch_angle);
      cp = poly_sine(r.pitch_angle + 16'h4000);
      sy = poly_sine(r.yaw_angle);
      cy = poly_sine(r.yaw_angle + 16'h4000);
      srsp = q30_mul(sr, sp);
      crsp = q30_mul(cr, sp);
      m00 = q30_mul(cp, cy);
      m01 = q30_mul(cp, sy);
      m02 = -sp;
      m10 = -q30_mul(cr, sy) + q30_mul(srsp, cy);
      m11 = q30_mul(cr, cy) + q30_mul(srsp, sy);
      m12 = q30_mul(sr, cp);
      m20 = q30_mul(sr, sy) + q30_mul(crsp, cy);
      m21 = -q30_mul(sr, cy) + q30_mul(crsp, sy);
      m22 = q30_mul(cr, cp);
      // Navigation frame is (-y, -x, -z); negation is done at 64 bits.
      p0 = -64'(r.world_pos_y);
      p1 = -64'(r.world_pos_x);
      p2 = -64'(r.world_pos_z);
      v0 = -64'(r.world_vel_y);
      v1 = -64'(r.world_vel_x);
      v2 = -64'(r.world_vel_z);
      o.body_pos_x = row_dot(m00, m01, m02, p0, p1, p2);
      o.body_pos_y = row_dot(m10, m11, m12, p0, p1, p2);
      o.body_pos_z = row_dot(m20, m21, m22, p0, p1, p2);
      o.body_vel_x = row_dot(m00, m01, m02, v0, v1, v2);
      o.body_vel_y = row_dot(m10, m11, m12, v0, v1, v2);
      o.body_vel_z = row_dot(m20, m21, m22, v0, v1, v2);
      return o;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(16'h4000 * $urandom_range(0, 3));
         3: return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic req_type make_req(input logic [15:0] ar, input logic [15:0] ap,
                                        input logic [15:0] ay, input logic [31:0] pw);
      req_type r;
      r.roll_angle = ar;
      r.pitch_angle = ap;
      r.yaw_angle = ay;
      r.world_pos_x = pw;
      r.world_pos_y = ~pw;
      r.world_pos_z = pw ^ 32'h0001_0000;
      r.world_vel_x = -pw;
      r.world_vel_y = pw;
      r.world_vel_z = ~pw;
      return r;
   endfunction

   // Driver: presents the next pending request, with random bursts of idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            owed_body.push_back(rotate_to_body(req_ch.data));
            n_sent <= n_sent + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
               req_gap <= $urandom_range(1, 13) - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_ch.data <= pending_reqs.pop_front();
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: takes each result and compares every field with the oldest prediction.
   always @(posedge clock) begin
      rsp_type exp_body;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_body.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("Unexpected result %h", rsp_ch.data);
            end else begin
               exp_body = owed_body.pop_front();
               n_checked <= n_checked + 1;
               if (rsp_ch.data.body_pos_x !== exp_body.body_pos_x ||
                   rsp_ch.data.body_pos_y !== exp_body.body_pos_y ||
                   rsp_ch.data.body_pos_z !== exp_body.body_pos_z ||
                   rsp_ch.data.body_vel_x !== exp_body.body_vel_x ||
                   rsp_ch.data.body_vel_y !== exp_body.body_vel_y ||
                   rsp_ch.data.body_vel_z !== exp_body.body_vel_z) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %h actual %h", exp_body, rsp_ch.data);
               end
            end
         end
         // The receiver stalls in bursts, except near the end of the run.
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            rsp_stall <= $urandom_range(1, 13) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      // Directed requests: angle extremes, quadrant edges, vector extremes.
      pending_reqs.push_back(make_req(16'h0000, 16'h0000, 16'h0000, 32'h0001_0000));
      pending_reqs.push_back(make_req(16'h7fff, 16'h8000, 16'h7fff, 32'h7fffffff));
      pending_reqs.push_back(make_req(16'h8000, 16'h7fff, 16'h8000, 32'h80000000));
      pending_reqs.push_back(make_req(16'h4000, 16'h4000, 16'h4000, 32'h80000000));
      pending_reqs.push_back(make_req(16'hc000, 16'hc000, 16'hc000, 32'h7fffffff));
      pending_reqs.push_back(make_req(16'h3fff, 16'h4001, 16'hbfff, 32'hffffffff));
      pending_reqs.push_back(make_req(16'hffff, 16'h0001, 16'h2000, 32'h0000_0000));
      pending_reqs.push_back(make_req(16'h2000, 16'he000, 16'h6000, 32'h5555_aaaa));
      pending_reqs.push_back(make_req(16'h0000, 16'h4000, 16'h0000, 32'h80000000));
      pending_reqs.push_back(make_req(16'h8000, 16'hc000, 16'h4000, 32'h7fffffff));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int k = 0; k < 600; k++) begin
         req_type r;
         r.roll_angle = pick_angle();
         r.pitch_angle = pick_angle();
         r.yaw_angle = pick_angle();
         r.world_pos_x = pick_word();
         r.world_pos_y = pick_word();
         r.world_pos_z = pick_word();
         r.world_vel_x = pick_word();
         r.world_vel_y = pick_word();
         r.world_vel_z = pick_word();
         pending_reqs.push_back(r);
      end
      // The last stretch runs with no idling on either side.
      wait (pending_reqs.size() < 80);
      @(posedge clock);
      calm_phase <= 1'b1;
      wait (pending_reqs.size() == 0 && !(req_ch.valid && !req_ch.ready));
      @(posedge clock);
      wait (owed_body.size() == 0);
      repeat (30) @(posedge clock);
      stim_done = 1'b1;
   end

   // Final verdict, or a timeout if the pipeline never drains.
   initial begin
      wait (stim_done || cycle_count >= CYCLE_LIMIT);
      if (!stim_done) begin
         $display("Timeout with %0d results still owed", owed_body.size());
         $display("Simulation FAILED");
      end else begin
         $display("Covered %0d requests with random stalls on both sides; %0d results checked.",
                  n_sent, n_checked);
         $display("Field mismatches or stray results: %0d", mismatches);
         if (mismatches == 0 && owed_body.size() == 0)
            $display("Simulation PASSED");
         else
            $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
